FILE: sv/spg_pkg.sv
// shared types, constants and command codes for the step pulse generator
// no dependencies; imported by spg_front, spg_back and the top level
`default_nettype none

package spg_pkg;

    localparam int HP_W       = 19;
    localparam int CNT_W      = 32;
    localparam int FREQ_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(HP_W + 1);

    localparam logic [HP_W-1:0] HALF_SEC_TICKS = HP_W'(500000);
    localparam logic [HP_W-1:0] HP_RESET       = HP_W'(500000 / 1000);

    // input opcodes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_SET_DIR = 3'd3;
    localparam logic [2:0] OP_SET_FREQ = 3'd4;
    localparam logic [2:0] OP_ENABLE  = 3'd5;
    localparam logic [2:0] OP_DISABLE = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_ACTIVE_LOW = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        K_TICK,
        K_START,
        K_STOP,
        K_SET_DIR,
        K_SET_FREQ,
        K_ENABLE,
        K_DISABLE,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CNT_W-1:0]  target;
        logic              fwd;
        logic [FREQ_W-1:0] freq;
    } t_cmd;

    typedef struct packed {
        logic dir_invert;
        logic enable_active_low;
    } t_cfg;

    typedef struct packed {
        logic             step_level;
        logic             dir_level;
        logic             enable_level;
        logic             running;
        logic [CNT_W-1:0] step_count;
        logic [HP_W-1:0]  half_period;
    } t_result;

    typedef enum logic {
        BK_EXEC,
        BK_DIV
    } t_back_state;

endpackage

`default_nettype wire

FILE: sv/spg_front.sv
// front end: decodes opcodes into command kinds and buffers them in a two-entry queue
// depends on spg_pkg
`default_nettype none

module spg_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    output logic              full,
    input  wire  [2:0]        i_opcode,
    input  wire  [31:0]       i_target_steps,
    input  wire               i_forward,
    input  wire  [19:0]       i_frequency_hz,
    output logic              o_cmd_valid,
    output spg_pkg::t_cmd     o_cmd,
    input  wire               i_cmd_pop
);
    import spg_pkg::*;

    t_cmd       r_queue [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.target = i_target_steps;
        w_cmd.fwd    = i_forward;
        w_cmd.freq   = i_frequency_hz;
        case (i_opcode)
            OP_TICK:     w_cmd.kind = K_TICK;
            OP_START:    w_cmd.kind = K_START;
            OP_STOP:     w_cmd.kind = K_STOP;
            OP_SET_DIR:  w_cmd.kind = K_SET_DIR;
            OP_SET_FREQ: w_cmd.kind = K_SET_FREQ;
            OP_ENABLE:   w_cmd.kind = K_ENABLE;
            OP_DISABLE:  w_cmd.kind = K_DISABLE;
            default:     w_cmd.kind = K_NOP;
        endcase
    end

    assign full        = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_head];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_tail <= !r_tail;
            end
            if (w_pop) begin
                r_head <= !r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_tail] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/spg_back.sv
// back end: generator state, iterative half-period divider and result register
// depends on spg_pkg
`default_nettype none

module spg_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cmd_valid,
    input  spg_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  spg_pkg::t_cfg      i_cfg,
    input  wire                i_pop,
    output logic               o_out_valid,
    output spg_pkg::t_result   o_result
);
    import spg_pkg::*;

    t_back_state          r_state,   n_state;
    logic [HP_W-1:0]      r_tick,    n_tick;
    logic [HP_W-1:0]      r_hp,      n_hp;
    logic [CNT_W-1:0]     r_issued,  n_issued;
    logic [CNT_W-1:0]     r_target,  n_target;
    logic                 r_run,     n_run;
    logic                 r_step,    n_step;
    logic                 r_fwd,     n_fwd;
    logic                 r_drv_en,  n_drv_en;
    logic [FREQ_W-1:0]    r_divisor, n_divisor;
    logic [FREQ_W-1:0]    r_rem,     n_rem;
    logic [HP_W-1:0]      r_quo,     n_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out,     n_out;

    logic                 w_out_free;
    logic                 w_load;
    logic [HP_W-1:0]      w_tick_inc;
    logic [DIV_CNT_W-1:0] w_bit_idx;
    logic [FREQ_W:0]      w_shifted;
    logic                 w_ge;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_tick_inc = r_tick + HP_W'(1);
    assign w_bit_idx  = r_div_cnt - DIV_CNT_W'(1);
    assign w_shifted  = {r_rem, HALF_SEC_TICKS[w_bit_idx[$clog2(HP_W)-1:0]]};
    assign w_ge       = (w_shifted >= {1'b0, r_divisor});

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_hp        = r_hp;
        n_issued    = r_issued;
        n_target    = r_target;
        n_run       = r_run;
        n_step      = r_step;
        n_fwd       = r_fwd;
        n_drv_en    = r_drv_en;
        n_divisor   = r_divisor;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        o_cmd_pop   = 1'b0;
        w_load      = 1'b0;

        case (r_state)
            BK_EXEC: begin
                if (i_cmd_valid && w_out_free) begin
                    o_cmd_pop = 1'b1;
                    w_load    = 1'b1;
                    case (i_cmd.kind)
                        K_TICK: begin
                            if (w_tick_inc >= r_hp) begin
                                n_tick = '0;
                                // one step-phase event
                                if (r_run) begin
                                    if (r_step) begin
                                        n_step = 1'b0;
                                    end else if (r_target != '0 && r_issued >= r_target) begin
                                        n_run = 1'b0;
                                    end else begin
                                        n_step   = 1'b1;
                                        n_issued = r_issued + CNT_W'(1);
                                    end
                                end
                            end else begin
                                n_tick = w_tick_inc;
                            end
                        end
                        K_START: begin
                            n_target = i_cmd.target;
                            n_issued = '0;
                            n_run    = 1'b1;
                            n_step   = 1'b0;
                            n_drv_en = 1'b1;
                        end
                        K_STOP: begin
                            n_run    = 1'b0;
                            n_step   = 1'b0;
                            n_drv_en = 1'b0;
                        end
                        K_SET_DIR: n_fwd = i_cmd.fwd;
                        K_SET_FREQ: begin
                            // result comes out when the divide finishes
                            w_load    = 1'b0;
                            n_divisor = (i_cmd.freq == '0) ? FREQ_W'(1) : i_cmd.freq;
                            n_rem     = '0;
                            n_quo     = '0;
                            n_div_cnt = DIV_CNT_W'(HP_W);
                            n_state   = BK_DIV;
                        end
                        K_ENABLE:  n_drv_en = 1'b1;
                        K_DISABLE: n_drv_en = 1'b0;
                        default: ;
                    endcase
                end
            end
            BK_DIV: begin
                if (r_div_cnt != '0) begin
                    // restoring divide, one quotient bit per cycle
                    n_rem     = w_ge ? FREQ_W'(w_shifted - {1'b0, r_divisor})
                                     : w_shifted[FREQ_W-1:0];
                    n_quo     = {r_quo[HP_W-2:0], w_ge};
                    n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
                end else if (w_out_free) begin
                    n_hp    = (r_quo == '0) ? HP_W'(1) : r_quo;
                    n_tick  = '0;
                    w_load  = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            default: n_state = BK_EXEC;
        endcase

        n_out.step_level   = n_step;
        n_out.dir_level    = n_fwd ^ i_cfg.dir_invert;
        n_out.enable_level = n_drv_en ^ i_cfg.enable_active_low;
        n_out.running      = n_run;
        n_out.step_count   = n_issued;
        n_out.half_period  = n_hp;

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_EXEC;
            r_tick      <= '0;
            r_hp        <= HP_RESET;
            r_issued    <= '0;
            r_target    <= '0;
            r_run       <= 1'b0;
            r_step      <= 1'b0;
            r_fwd       <= 1'b1;
            r_drv_en    <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_hp        <= n_hp;
            r_issued    <= n_issued;
            r_target    <= n_target;
            r_run       <= n_run;
            r_step      <= n_step;
            r_fwd       <= n_fwd;
            r_drv_en    <= n_drv_en;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_divisor <= n_divisor;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

FILE: sv/stepper_step_pulse_generator.sv
// top level of the step/dir/enable pulse generator: config registers and port mapping
// depends on spg_pkg, spg_front and spg_back
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------------------
//  command   push / full               i_opcode i_target_steps i_forward i_frequency_hz
//  result    pop / empty               o_step_level o_dir_level o_enable_level o_running
//                                      o_step_count o_half_period
//  config    i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
//  one command per cycle for ticks and all other opcodes except set frequency while
//  the result register is free; set frequency holds the back end while it takes the
//  command, runs 19 steps of the restoring divider and commits the new half period
//  once the result register is free; the two-entry queue absorbs commands meanwhile
//  every accepted command yields exactly one result, taken from a single output register
//  reset is synchronous and active low; no clearing pass is needed after it
`default_nettype none

module stepper_step_pulse_generator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [2:0]  i_opcode,
    input  wire  [31:0] i_target_steps,
    input  wire         i_forward,
    input  wire  [19:0] i_frequency_hz,
    output logic        empty,
    input  wire         pop,
    output logic        o_step_level,
    output logic        o_dir_level,
    output logic        o_enable_level,
    output logic        o_running,
    output logic [31:0] o_step_count,
    output logic [18:0] o_half_period,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [spg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire         i_cfg_data
);
    import spg_pkg::*;

    t_cfg    r_cfg;
    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_pop;
    logic    w_out_valid;
    t_result w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_invert        <= 1'b0;
            r_cfg.enable_active_low <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIR_INVERT:        r_cfg.dir_invert        <= i_cfg_data;
                CFG_ENABLE_ACTIVE_LOW: r_cfg.enable_active_low <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_target_steps (i_target_steps),
        .i_forward      (i_forward),
        .i_frequency_hz (i_frequency_hz),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    spg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg       (r_cfg),
        .i_pop       (pop),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign empty          = !w_out_valid;
    assign o_step_level   = w_result.step_level;
    assign o_dir_level    = w_result.dir_level;
    assign o_enable_level = w_result.enable_level;
    assign o_running      = w_result.running;
    assign o_step_count   = w_result.step_count;
    assign o_half_period  = w_result.half_period;

`ifndef SYNTH
    // a waiting result is never dropped without a pop
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result lost without pop");

    // the half period is never zero
    a_hp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_half_period != '0))
        else $error("half period is zero");

    // step can only be high while the generator runs
    a_step_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_step_level) |-> o_running)
        else $error("step high while not running");

    // the back end never pops from an empty command queue
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for the step/dir/enable pulse generator: directed and random commands,
// a predictor of pin levels kept in a small scoreboard class, random stalls on both queue sides
// depends on spg_pkg and stepper_step_pulse_generator
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spg_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int unsigned HALF_SECOND = 500000;
    localparam int unsigned HP_CEILING = (1 << HP_W) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_FROM = 460;

    class pulse_expectations;
        bit dir_invert;
        bit enable_low;
        logic [HP_W-1:0] tick_count;
        logic [HP_W-1:0] half_ticks;
        logic [CNT_W-1:0] issued;
        logic [CNT_W-1:0] goal;
        bit running;
        bit step_hi;
        bit fwd_dir;
        bit drv_on;
        t_result expected_pins[$];
        int unsigned errors;

        function new();
            dir_invert = 1'b0;
            enable_low = 1'b1;
            tick_count = '0;
            half_ticks = half_period_for(20'd1000);
            issued = '0;
            goal = '0;
            running = 1'b0;
            step_hi = 1'b0;
            fwd_dir = 1'b1;
            drv_on = 1'b0;
            errors = 0;
        endfunction

        function logic [HP_W-1:0] half_period_for(logic [FREQ_W-1:0] hz);
            int unsigned f;
            int unsigned q;
            f = (hz == '0) ? 1 : int'(hz);
            q = HALF_SECOND / f;
            if (q < 1) q = 1;
            if (q > HP_CEILING) q = HP_CEILING;
            return q[HP_W-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, bit val);
            if (idx == CFG_DIR_INVERT) dir_invert = val;
            else if (idx == CFG_ENABLE_ACTIVE_LOW) enable_low = val;
        endfunction

        // one half-period boundary while running
        function void phase_edge();
            if (!running) return;
            if (step_hi) begin
                step_hi = 1'b0;
                return;
            end
            if (goal != '0 && issued >= goal) begin
                running = 1'b0;
                return;
            end
            step_hi = 1'b1;
            issued = issued + 1'b1;
        endfunction

        function void note_command(logic [2:0] op, logic [31:0] tgt, logic fwd,
                                   logic [19:0] hz);
            t_result r;
            case (op)
                OP_TICK: begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count >= half_ticks) begin
                        tick_count = '0;
                        phase_edge();
                    end
                end
                OP_START: begin
                    goal = tgt;
                    issued = '0;
                    running = 1'b1;
                    step_hi = 1'b0;
                    drv_on = 1'b1;
                end
                OP_STOP: begin
                    running = 1'b0;
                    step_hi = 1'b0;
                    drv_on = 1'b0;
                end
                OP_SET_DIR: fwd_dir = fwd;
                OP_SET_FREQ: begin
                    half_ticks = half_period_for(hz);
                    tick_count = '0;
                end
                OP_ENABLE: drv_on = 1'b1;
                OP_DISABLE: drv_on = 1'b0;
                default: ;
            endcase
            r.step_level = step_hi;
            r.dir_level = fwd_dir ^ dir_invert;
            r.enable_level = drv_on ^ enable_low;
            r.running = running;
            r.step_count = issued;
            r.half_period = half_ticks;
            expected_pins.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10) $display("error: %s expected %0h got %0h", what, want, got);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) flag(what, want, got);
        endfunction

        function void check_pins(t_result got);
            t_result want;
            if (expected_pins.size() == 0) begin
                flag("result with no command outstanding, step_count", '0, got.step_count);
                return;
            end
            want = expected_pins.pop_front();
            compare_field("step_level", want.step_level, got.step_level);
            compare_field("dir_level", want.dir_level, got.dir_level);
            compare_field("enable_level", want.enable_level, got.enable_level);
            compare_field("running", want.running, got.running);
            compare_field("step_count", want.step_count, got.step_count);
            compare_field("half_period", want.half_period, got.half_period);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic [2:0] i_opcode = OP_TICK;
    logic [31:0] i_target_steps = '0;
    logic i_forward = 1'b0;
    logic [19:0] i_frequency_hz = '0;
    logic pop = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_DIR_INVERT;
    logic i_cfg_data = 1'b0;

    wire full;
    wire empty;
    wire o_step_level;
    wire o_dir_level;
    wire o_enable_level;
    wire o_running;
    wire [31:0] o_step_count;
    wire [18:0] o_half_period;
    wire o_cfg_ready;

    pulse_expectations sb = new();
    int sent = 0;
    int cycles = 0;
    int pop_hold = 0;
    bit send_gaps = 1'b1;
    bit take_gaps = 1'b1;

    stepper_step_pulse_generator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_opcode(i_opcode),
        .i_target_steps(i_target_steps),
        .i_forward(i_forward),
        .i_frequency_hz(i_frequency_hz),
        .empty(empty),
        .pop(pop),
        .o_step_level(o_step_level),
        .o_dir_level(o_dir_level),
        .o_enable_level(o_enable_level),
        .o_running(o_running),
        .o_step_count(o_step_count),
        .o_half_period(o_half_period),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("stepper_step_pulse_generator: mismatch");
            $finish;
        end
    end

    // result side holds pop low in random bursts while take_gaps is set
    always @(posedge i_clk) begin
        if (!take_gaps) begin
            pop <= 1'b1;
        end else if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else if ($urandom_range(0, 11) == 0) begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(0, 15);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_pins({o_step_level, o_dir_level, o_enable_level, o_running,
                           o_step_count, o_half_period});
    end

    task automatic send_cmd(input logic [2:0] op, input logic [31:0] tgt, input logic fwd,
                            input logic [19:0] hz);
        if (send_gaps && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_opcode <= op;
        i_target_steps <= tgt;
        i_forward <= fwd;
        i_frequency_hz <= hz;
        do @(posedge i_clk); while (full);
        sb.note_command(op, tgt, fwd, hz);
        sent++;
    endtask

    // only with the command queue drained and every result taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit val);
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_pins.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic logic [19:0] any_hz();
        return 20'($urandom_range(0, 20'hFFFFF));
    endfunction

    // set a fast rate, start, then mostly ticks so steps and target stops happen
    task automatic run_profile();
        logic [19:0] hz;
        logic [31:0] tgt;
        int n;
        hz = ($urandom_range(0, 3) == 0) ? any_hz() : 20'($urandom_range(83334, 20'hFFFFF));
        send_cmd(OP_SET_FREQ, $urandom(), 1'($urandom()), hz);
        if ($urandom_range(0, 1) == 1) send_cmd(OP_SET_DIR, $urandom(), 1'($urandom()), any_hz());
        case ($urandom_range(0, 3))
            0: tgt = '0;
            3: tgt = $urandom();
            default: tgt = $urandom_range(1, 6);
        endcase
        send_cmd(OP_START, tgt, 1'($urandom()), any_hz());
        n = $urandom_range(5, 40);
        repeat (n) begin
            case ($urandom_range(0, 19))
                0: send_cmd(OP_SET_DIR, $urandom(), 1'($urandom()), any_hz());
                1: send_cmd(OP_ENABLE, $urandom(), 1'($urandom()), any_hz());
                2: send_cmd(OP_DISABLE, $urandom(), 1'($urandom()), any_hz());
                default: send_cmd(OP_TICK, $urandom(), 1'($urandom()), any_hz());
            endcase
        end
        if ($urandom_range(0, 2) == 0) send_cmd(OP_STOP, $urandom(), 1'($urandom()), any_hz());
    endtask

    task automatic run_random(input int upto);
        while (sent < upto) begin
            if (sent >= QUIET_FROM) begin
                send_gaps = 1'b0;
                take_gaps = 1'b0;
            end
            if ($urandom_range(0, 3) != 0) begin
                run_profile();
            end else begin
                repeat ($urandom_range(1, 8))
                    send_cmd(3'($urandom_range(0, 7)), $urandom(), 1'($urandom()), any_hz());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle tick, unused code, rate clamp at zero and floor at full scale
        send_cmd(OP_TICK, '0, 1'b0, '0);
        send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
        send_cmd(OP_SET_FREQ, '0, 1'b0, 20'd0);
        send_cmd(OP_SET_DIR, '0, 1'b0, '0);
        send_cmd(OP_ENABLE, '0, 1'b0, '0);
        send_cmd(OP_DISABLE, '0, 1'b0, '0);
        send_cmd(OP_SET_DIR, '0, 1'b1, '0);
        send_cmd(OP_SET_FREQ, '0, 1'b0, 20'hFFFFF);
        // three steps at one tick per half period, then the target stop
        send_cmd(OP_START, 32'd3, 1'b0, '0);
        repeat (8) send_cmd(OP_TICK, '0, 1'b0, '0);
        send_cmd(OP_SET_FREQ, '0, 1'b0, 20'd250000);
        send_cmd(OP_START, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
        repeat (4) send_cmd(OP_TICK, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF);
        send_cmd(OP_STOP, '0, 1'b0, '0);
        // continuous run
        send_cmd(OP_START, '0, 1'b0, '0);
        repeat (2) send_cmd(OP_TICK, '0, 1'b0, '0);

        run_random(150);
        write_reg(CFG_DIR_INVERT, 1'b1);
        write_reg(CFG_ENABLE_ACTIVE_LOW, 1'b0);
        run_random(275);
        write_reg(CFG_ENABLE_ACTIVE_LOW, 1'b1);
        run_random(400);
        write_reg(CFG_DIR_INVERT, 1'b0);
        write_reg(CFG_ENABLE_ACTIVE_LOW, 1'b0);
        run_random(525);

        push <= 1'b0;
        while (sb.expected_pins.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("stepper_step_pulse_generator: match");
        end else begin
            $display("stepper_step_pulse_generator: mismatch");
        end
        $finish;
    end
endmodule
